FILE: rtl/itrt_pkg.sv
// ----------------------------------------------------------------------------
// itrt_pkg: shared types and constants for the integer to radix text block
// Holds the sequencer state encoding, register indexes, character codes and
// the reciprocal table used by the digit extraction unit.
// ----------------------------------------------------------------------------
package itrt_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_DIGIT_COUNT = 2'd0;
  localparam logic [1:0] REG_DIGITS_LOW  = 2'd1;
  localparam logic [1:0] REG_DIGITS_HIGH = 2'd2;

  // Character codes used by the alphabet check and the sign beat
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_DEL   = 8'd127;

  // Smallest usable radix, alphabet slots held in the two registers
  localparam logic [4:0] MIN_RADIX   = 5'd2;
  localparam int         ALPHA_SLOTS = 16;
  localparam int         SLOT_W      = 4;

  // Sequencer states
  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_INVALID = 7'b0000010,
    ST_MUL     = 7'b0000100,
    ST_FIX     = 7'b0001000,
    ST_SIGN    = 7'b0010000,
    ST_RD      = 7'b0100000,
    ST_EMIT    = 7'b1000000
  } state_e;

  // floor(2^32 / radix); the quotient estimate from it is low by at most one
  function automatic logic [31:0] recip_of(input logic [4:0] radix);
    logic [31:0] r;
    case (radix)
      5'd2:    r = 32'h8000_0000;
      5'd3:    r = 32'h5555_5555;
      5'd4:    r = 32'h4000_0000;
      5'd5:    r = 32'h3333_3333;
      5'd6:    r = 32'h2AAA_AAAA;
      5'd7:    r = 32'h2492_4924;
      5'd8:    r = 32'h2000_0000;
      5'd9:    r = 32'h1C71_C71C;
      5'd10:   r = 32'h1999_9999;
      5'd11:   r = 32'h1745_D174;
      5'd12:   r = 32'h1555_5555;
      5'd13:   r = 32'h13B1_3B13;
      5'd14:   r = 32'h1249_2492;
      5'd15:   r = 32'h1111_1111;
      5'd16:   r = 32'h1000_0000;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/int_to_radix_text.sv
// ----------------------------------------------------------------------------
// int_to_radix_text: signed 32-bit integer to text in a configurable radix
// Converts one value into a minus sign (if negative) and its digit
// characters, most significant first, using a configured digit alphabet.
// ----------------------------------------------------------------------------
// Usage
//   Configuration: write digit_count (index 0), digits_low (1) and
//   digits_high (2) over the cfg channel while the block is idle; cfg_ready_o
//   is always high. Byte k of the alphabet is the character for digit k.
//   Input: one value beat is taken when in_valid_i is high and in_stall_o is
//   low. in_stall_o stays high until the last result beat of the item has
//   been loaded into the output register.
//   Output: one beat per character, last_o on the final one. A rejected
//   alphabet gives a single beat with base_invalid_o set, character 0.
// Timing
//   Digits come from one shared reciprocal multiplier: a multiply step, then
//   a remainder correction step per digit, D digits with D <= DIGIT_DEPTH.
//   A negative value adds a step for the sign beat, and the stack read
//   adds a step before the first digit, after which digits stream one per
//   cycle while the output does not stall. The next value is taken in the
//   idle state. A rejected alphabet passes through the invalid state alone.
//   An output stall holds the current beat and stops the sequencer at each
//   beat it loads.
// Reset clears the configuration registers, sequencer and output valid.
// ----------------------------------------------------------------------------
module int_to_radix_text
  import itrt_pkg::*;
#(
  parameter int MAX_RADIX   = 16,
  parameter int DIGIT_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] value_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         character_o,
  output logic               last_o,
  output logic               base_invalid_o
);

  localparam int DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int CW      = $clog2(DIGIT_DEPTH + 1);
  localparam int AW      = $clog2(DIGIT_DEPTH);

  // Configuration registers
  logic [4:0]  digit_count_q;
  logic [63:0] digits_low_q;
  logic [63:0] digits_high_q;

  // Sequencer and datapath registers
  state_e               state_q, state_d;
  logic                 neg_q, neg_d;
  logic [31:0]          rest_q, rest_d;
  logic [31:0]          recip_q, recip_d;
  logic [4:0]           radix_q, radix_d;
  logic [31:0]          q0_q, q0_d;
  logic [CW-1:0]        count_q, count_d;
  logic [DIGIT_W-1:0]   rd_data_q;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;
  logic                 out_bad_q, out_bad_d;

  // Digit stack
  logic [DIGIT_W-1:0]   stack_mem [DIGIT_DEPTH];
  logic                 st_wr;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;

  logic [127:0]         alphabet_w;
  logic                 alpha_bad;
  logic                 in_acc;
  logic                 out_free;
  logic [31:0]          raw_w;
  logic [31:0]          mag_w;
  logic [63:0]          prod_w;
  logic [36:0]          back_w;
  logic [31:0]          r_w;
  logic                 ge_w;
  logic [31:0]          r_fix_w;
  logic [DIGIT_W-1:0]   rem_w;
  logic [31:0]          quot_w;
  logic [CW-1:0]        cnt_p1;
  logic [CW-1:0]        cnt_m1;
  logic [CW-1:0]        cnt_m2;
  logic [SLOT_W-1:0]    slot_w;
  logic [7:0]           digit_char_w;

  assign cfg_ready_o = 1'b1;
  assign alphabet_w  = {digits_high_q, digits_low_q};

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= '0;
      digits_low_q  <= '0;
      digits_high_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DIGIT_COUNT: digit_count_q <= cfg_data_i[4:0];
        REG_DIGITS_LOW:  digits_low_q  <= cfg_data_i;
        REG_DIGITS_HIGH: digits_high_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // Alphabet check: parallel compares over the sixteen slots
  always_comb begin
    logic [7:0] ci;
    alpha_bad = (digit_count_q < MIN_RADIX) || (digit_count_q > 5'(MAX_RADIX));
    for (int i = 0; i < ALPHA_SLOTS; i++) begin
      ci = alphabet_w[i*8 +: 8];
      if (5'(i) < digit_count_q) begin
        if (ci == CHAR_PLUS || ci == CHAR_MINUS || ci <= CHAR_SPACE ||
            ci == CHAR_DEL || ci[7]) begin
          alpha_bad = 1'b1;
        end
        for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
          if (5'(j) < digit_count_q && alphabet_w[j*8 +: 8] == ci) begin
            alpha_bad = 1'b1;
          end
        end
      end
    end
  end

  // Handshakes
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sign and magnitude of the incoming value
  assign raw_w = unsigned'(value_i);
  assign mag_w = raw_w[31] ? (32'd0 - raw_w) : raw_w;

  // Shared divide unit: reciprocal multiply, then remainder and correction
  assign prod_w  = rest_q * recip_q;
  assign back_w  = q0_q * radix_q;
  assign r_w     = rest_q - back_w[31:0];
  assign ge_w    = (r_w >= 32'(radix_q));
  assign r_fix_w = ge_w ? (r_w - 32'(radix_q)) : r_w;
  assign rem_w   = r_fix_w[DIGIT_W-1:0];
  assign quot_w  = q0_q + 32'(ge_w);

  assign cnt_p1 = count_q + CW'(1);
  assign cnt_m1 = count_q - CW'(1);
  assign cnt_m2 = count_q - CW'(2);

  // Character lookup for the digit read back from the stack
  assign slot_w       = SLOT_W'(rd_data_q);
  assign digit_char_w = alphabet_w[slot_w*8 +: 8];

  // Sequencer
  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    rest_d      = rest_q;
    recip_d     = recip_q;
    radix_d     = radix_q;
    q0_d        = q0_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;
    st_wr       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cnt_m1[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (alpha_bad) begin
            state_d = ST_INVALID;
          end else begin
            neg_d   = raw_w[31];
            rest_d  = mag_w;
            radix_d = digit_count_q;
            recip_d = recip_of(digit_count_q);
            count_d = '0;
            state_d = ST_MUL;
          end
        end
      end
      ST_INVALID: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = '0;
          out_last_d  = 1'b1;
          out_bad_d   = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_MUL: begin
        q0_d    = prod_w[63:32];
        state_d = ST_FIX;
      end
      ST_FIX: begin
        // push the remainder, carry on with the quotient
        st_wr   = 1'b1;
        rest_d  = quot_w;
        count_d = cnt_p1;
        if (quot_w == '0 || cnt_p1 == CW'(DIGIT_DEPTH)) begin
          state_d = neg_q ? ST_SIGN : ST_RD;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
          out_bad_d   = 1'b0;
          state_d     = ST_RD;
        end
      end
      ST_RD: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m1[AW-1:0];
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // one digit per cycle while the output is free, next stack entry prefetched
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_char_w;
          out_last_d  = (count_q == CW'(1));
          out_bad_d   = 1'b0;
          count_d     = cnt_m1;
          if (count_q == CW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cnt_m2[AW-1:0];
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      neg_q       <= neg_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rest_q     <= rest_d;
    recip_q    <= recip_d;
    radix_q    <= radix_d;
    q0_q       <= q0_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_bad_q  <= out_bad_d;
  end

  // Digit stack: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (st_wr) begin
      stack_mem[count_q[AW-1:0]] <= rem_w;
    end
    if (rd_en) begin
      rd_data_q <= stack_mem[rd_addr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign character_o    = out_char_q;
  assign last_o         = out_last_q;
  assign base_invalid_o = out_bad_q;

  // Checks
  a_invalid_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && base_invalid_o |-> last_o && character_o == 8'd0)
    else $error("invalid-alphabet beat must be a lone zero beat");

  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !alpha_bad |=> state_q == ST_MUL)
    else $error("accepted value did not start digit extraction");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIX |-> r_fix_w < 32'(radix_q))
    else $error("remainder correction left a value at or above the radix");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DIGIT_DEPTH))
    else $error("digit count beyond stack depth");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT || state_q == ST_RD |-> count_q != '0)
    else $error("emitting from an empty digit stack");

endmodule
